### src/mstb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mstb_pkg
// Shared types, codes and sizes for the countdown timer bank.
// ----------------------------------------------------------------------------
package mstb_pkg;

   localparam int NUM_SLOTS       = 16;
   localparam int COUNT_WIDTH     = 32;
   localparam int ID_WIDTH        = 4;
   localparam int TICKS_WIDTH     = 32;
   localparam int ADDR_SLOTS      = 1 << ID_WIDTH;
   localparam int SCAN_SLOTS      = (NUM_SLOTS < ADDR_SLOTS) ? NUM_SLOTS : ADDR_SLOTS;
   localparam int SLOT_IDX_WIDTH  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SCAN_IDX_WIDTH  = (SCAN_SLOTS > 1) ? $clog2(SCAN_SLOTS) : 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = 1;
   localparam int QUEUE_CNT_WIDTH = 2;

   typedef logic [1:0]             op_type;
   typedef logic [1:0]             err_type;
   typedef logic [ID_WIDTH-1:0]    id_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam op_type OP_TICK   = 2'd0;
   localparam op_type OP_ARM    = 2'd1;
   localparam op_type OP_REARM  = 2'd2;
   localparam op_type OP_DISARM = 2'd3;

   localparam err_type ERR_NONE        = 2'd0;
   localparam err_type ERR_ZERO_TICKS  = 2'd1;
   localparam err_type ERR_ALREADY_ARM = 2'd2;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef struct packed {
      op_type    op;
      id_type    id;
      logic      in_range;
      logic      ticks_zero;
      count_type ticks;
      count_type interval;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      logic    kind;
      id_type  slot_id;
      logic    prev_armed;
      err_type error;
      logic    last;
   } rsp_type;

   function automatic count_type to_count(input logic [TICKS_WIDTH-1:0] v);
      logic [2*TICKS_WIDTH-1:0] w;
      w = {{TICKS_WIDTH{1'b0}}, v};
      return w[COUNT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

### src/multi_slot_countdown_timer_bank_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_bank_top
// Bank of one-shot and periodic countdown timers driven by request commands.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request (tick, arm, rearm, disarm) is taken on a rising
//   edge with start high and busy low. Requests go into a two-entry queue;
//   busy is high while that queue is full.
//   Response channel: each response is shown for one cycle with rsp_valid
//   high. Arm, rearm and disarm give one acknowledge (last set). A tick gives
//   one expiry per expiring slot, in ascending slot order, last set on the
//   final one, and nothing if no slot expires.
//   A command is acknowledged after it passes the queue, the sequencer's idle
//   and command states and the response register. A tick scans all slots
//   with one shared decrementer, one slot per cycle; an expiry is held until
//   the next expiring slot is scanned or the scan ends, so the last one
//   passes the flush state and the response register after the final slot.
//   The sequencer takes no new request from the queue until it is back idle.
//   Reset (synchronous) clears the queue, all armed flags and reload values.
//   The receiver cannot stall; responses are never held back.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_bank_top
   import mstb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_operation,
   input  wire logic [ID_WIDTH-1:0]    req_timer_id,
   input  wire logic [TICKS_WIDTH-1:0] req_ticks,
   input  wire logic [TICKS_WIDTH-1:0] req_interval,
   output logic                        rsp_valid,
   output logic                        rsp_kind,
   output logic [ID_WIDTH-1:0]         rsp_slot_id,
   output logic                        rsp_prev_armed,
   output logic [1:0]                  rsp_error,
   output logic                        rsp_last
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    pop;
   rsp_type rsp;

   mstb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .operation (req_operation),
      .timer_id  (req_timer_id),
      .ticks     (req_ticks),
      .interval  (req_interval),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop)
   );

   mstb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_valid      = rsp.valid;
   assign rsp_kind       = rsp.kind;
   assign rsp_slot_id    = rsp.slot_id;
   assign rsp_prev_armed = rsp.prev_armed;
   assign rsp_error      = rsp.error;
   assign rsp_last       = rsp.last;

endmodule
`default_nettype wire

### src/mstb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mstb_front
// Request intake: classifies requests and buffers them in a short queue.
// ----------------------------------------------------------------------------
module mstb_front
   import mstb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             operation,
   input  wire logic [ID_WIDTH-1:0]    timer_id,
   input  wire logic [TICKS_WIDTH-1:0] ticks,
   input  wire logic [TICKS_WIDTH-1:0] interval,
   output logic                        cmd_valid,
   output cmd_type                     cmd,
   input  wire logic                   pop
);

   cmd_type                      queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                         accept;
   cmd_type                      entry;

   assign busy      = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign accept    = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      entry.op         = operation;
      entry.id         = timer_id;
      entry.in_range   = (32'(timer_id) < 32'(NUM_SLOTS));
      entry.ticks      = to_count(ticks);
      entry.interval   = to_count(interval);
      entry.ticks_zero = (entry.ticks == '0);
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
   a_accept_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted request not queued");
`endif

endmodule
`default_nettype wire

### src/mstb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mstb_back
// Slot state and sequencer: executes commands and scans slots on a tick.
// ----------------------------------------------------------------------------
module mstb_back
   import mstb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         pop,
   output rsp_type      rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMD   = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]                state_ff, state_in;
   cmd_type                   cur_ff, cur_in;
   logic [SCAN_IDX_WIDTH-1:0] scan_idx_ff, scan_idx_in;
   logic                      pend_valid_ff, pend_valid_in;
   id_type                    pend_slot_ff, pend_slot_in;
   rsp_type                   rsp_ff, rsp_in;
   logic [NUM_SLOTS-1:0]      armed_ff;
   count_type                 count_ff  [NUM_SLOTS];
   count_type                 reload_ff [NUM_SLOTS];

   logic [SLOT_IDX_WIDTH-1:0] rd_slot;
   logic                      rd_armed;
   count_type                 rd_count, rd_reload, dec;
   logic                      expire;
   id_type                    scan_id;
   logic                      arm_we, arm_wdata;
   logic                      cnt_we, rel_we;
   count_type                 cnt_wdata, rel_wdata;

   assign rsp     = rsp_ff;
   assign scan_id = ID_WIDTH'(scan_idx_ff);
   assign rd_slot = (state_ff == ST_SCAN) ? SLOT_IDX_WIDTH'(scan_idx_ff)
                                          : SLOT_IDX_WIDTH'(cur_ff.id);
   assign rd_armed  = armed_ff[rd_slot];
   assign rd_count  = count_ff[rd_slot];
   assign rd_reload = reload_ff[rd_slot];
   assign dec       = rd_count - 1'b1;
   assign expire    = rd_armed && (dec == '0);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_in        = '0;
      pop           = 1'b0;
      arm_we        = 1'b0;
      arm_wdata     = 1'b0;
      cnt_we        = 1'b0;
      cnt_wdata     = '0;
      rel_we        = 1'b0;
      rel_wdata     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               pop           = 1'b1;
               cur_in        = cmd;
               scan_idx_in   = '0;
               pend_valid_in = 1'b0;
               state_in      = (cmd.op == OP_TICK) ? ST_SCAN : ST_CMD;
            end
         end
         ST_CMD: begin
            rsp_in.valid   = 1'b1;
            rsp_in.kind    = KIND_ACK;
            rsp_in.slot_id = cur_ff.id;
            rsp_in.last    = 1'b1;
            rsp_in.error   = ERR_NONE;
            if (cur_ff.in_range) begin
               rsp_in.prev_armed = rd_armed;
               unique case (cur_ff.op)
                  OP_ARM: begin
                     if (cur_ff.ticks_zero) begin
                        rsp_in.error = ERR_ZERO_TICKS;
                     end else if (rd_armed) begin
                        rsp_in.error = ERR_ALREADY_ARM;
                     end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cur_ff.ticks;
                        rel_we    = 1'b1;
                        rel_wdata = cur_ff.interval;
                        arm_we    = 1'b1;
                        arm_wdata = 1'b1;
                     end
                  end
                  OP_REARM: begin
                     if (cur_ff.ticks_zero) begin
                        rsp_in.error = ERR_ZERO_TICKS;
                     end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cur_ff.ticks;
                        arm_we    = 1'b1;
                        arm_wdata = 1'b1;
                     end
                  end
                  OP_DISARM: begin
                     cnt_we    = 1'b1;
                     cnt_wdata = '0;
                     arm_we    = 1'b1;
                     arm_wdata = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (rd_armed) begin
               cnt_we    = 1'b1;
               cnt_wdata = (expire && (rd_reload != '0)) ? rd_reload : dec;
            end
            if (expire) begin
               if (rd_reload == '0) begin
                  arm_we    = 1'b1;
                  arm_wdata = 1'b0;
               end
               if (pend_valid_ff) begin
                  rsp_in.valid      = 1'b1;
                  rsp_in.kind       = KIND_EXPIRY;
                  rsp_in.slot_id    = pend_slot_ff;
                  rsp_in.prev_armed = 1'b1;
                  rsp_in.error      = ERR_NONE;
                  rsp_in.last       = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = scan_id;
            end
            if (scan_idx_ff == SCAN_IDX_WIDTH'(SCAN_SLOTS - 1)) begin
               state_in = ST_FLUSH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_in.valid      = 1'b1;
               rsp_in.kind       = KIND_EXPIRY;
               rsp_in.slot_id    = pend_slot_ff;
               rsp_in.prev_armed = 1'b1;
               rsp_in.error      = ERR_NONE;
               rsp_in.last       = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_ff        <= '0;
         armed_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_ff        <= rsp_in;
         if (arm_we) begin
            armed_ff[rd_slot] <= arm_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      scan_idx_ff  <= scan_idx_in;
      pend_slot_ff <= pend_slot_in;
      if (cnt_we) begin
         count_ff[rd_slot] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            reload_ff[i] <= '0;
         end
      end else if (rel_we) begin
         reload_ff[rd_slot] <= rel_wdata;
      end
   end

`ifndef ASSERT_OFF
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && rsp_ff.kind == KIND_ACK) |-> rsp_ff.last)
      else $error("acknowledge without last mark");
   a_cmd_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMD |=> (state_ff == ST_IDLE && rsp_ff.valid))
      else $error("command did not acknowledge in one cycle");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("pending expiry left over after scan");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE && cmd_valid))
      else $error("pop outside idle");
`endif

endmodule
`default_nettype wire
